// ===== rtl/ssg_pkg.sv =====
// ----------------------------------------------------------------------------
// ssg_pkg
// Shared types and constants for the slider swipe/tap gesture detector.
// ----------------------------------------------------------------------------
`default_nettype none

package ssg_pkg;

  localparam int unsigned MASK_WIDTH_DEF     = 8;
  localparam int unsigned POSITION_WIDTH_DEF = 8;
  localparam int unsigned CFG_WIDTH          = 8;
  localparam int unsigned CFG_INDEX_WIDTH    = 3;
  localparam int unsigned GESTURE_WIDTH      = 3;

  typedef enum logic [GESTURE_WIDTH-1:0] {
    GEST_NONE        = 3'd0,
    GEST_LARGE       = 3'd1,
    GEST_SWIPE_LEFT  = 3'd2,
    GEST_SWIPE_RIGHT = 3'd3,
    GEST_TAP         = 3'd4
  } gesture_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_SLIDER_SENSOR_MASK = 3'd0,
    CFG_LARGE_OBJECT_SCANS = 3'd1,
    CFG_SWIPE_MIN_DISTANCE = 3'd2,
    CFG_SWIPE_MIN_TICKS    = 3'd3,
    CFG_SWIPE_MAX_TICKS    = 3'd4,
    CFG_TAP_MAX_DISTANCE   = 3'd5,
    CFG_TAP_MIN_TICKS      = 3'd6,
    CFG_TAP_MAX_TICKS      = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] slider_sensor_mask;
    logic [CFG_WIDTH-1:0] large_object_scans;
    logic [CFG_WIDTH-1:0] swipe_min_distance;
    logic [CFG_WIDTH-1:0] swipe_min_ticks;
    logic [CFG_WIDTH-1:0] swipe_max_ticks;
    logic [CFG_WIDTH-1:0] tap_max_distance;
    logic [CFG_WIDTH-1:0] tap_min_ticks;
    logic [CFG_WIDTH-1:0] tap_max_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    slider_sensor_mask: 8'd31,
    large_object_scans: 8'd3,
    swipe_min_distance: 8'd30,
    swipe_min_ticks:    8'd2,
    swipe_max_ticks:    8'd40,
    tap_max_distance:   8'd10,
    tap_min_ticks:      8'd1,
    tap_max_ticks:      8'd20
  };

endpackage

`default_nettype wire

// ===== rtl/ssg_cfg.sv =====
// ----------------------------------------------------------------------------
// ssg_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module ssg_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [ssg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [ssg_pkg::CFG_WIDTH-1:0]       cfg_data,
  output ssg_pkg::cfg_t                            cfg
);

  import ssg_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SLIDER_SENSOR_MASK: regs.slider_sensor_mask <= cfg_data;
        CFG_LARGE_OBJECT_SCANS: regs.large_object_scans <= cfg_data;
        CFG_SWIPE_MIN_DISTANCE: regs.swipe_min_distance <= cfg_data;
        CFG_SWIPE_MIN_TICKS:    regs.swipe_min_ticks    <= cfg_data;
        CFG_SWIPE_MAX_TICKS:    regs.swipe_max_ticks    <= cfg_data;
        CFG_TAP_MAX_DISTANCE:   regs.tap_max_distance   <= cfg_data;
        CFG_TAP_MIN_TICKS:      regs.tap_min_ticks      <= cfg_data;
        CFG_TAP_MAX_TICKS:      regs.tap_max_ticks      <= cfg_data;
        default:                regs <= regs;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// ===== rtl/ssg_track.sv =====
// ----------------------------------------------------------------------------
// ssg_track
// Touch tracking state and per-scan gesture decision. State advances on step.
// ----------------------------------------------------------------------------
`default_nettype none

module ssg_track #(
  parameter int unsigned MASK_WIDTH     = ssg_pkg::MASK_WIDTH_DEF,
  parameter int unsigned POSITION_WIDTH = ssg_pkg::POSITION_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  ssg_pkg::cfg_t                  cfg,
  input  wire logic                      step,
  input  wire logic [MASK_WIDTH-1:0]     sensor_on_bits,
  input  wire logic [POSITION_WIDTH-1:0] centroid_position,
  input  wire logic                      centroid_present,
  output ssg_pkg::gesture_t              gesture_code,
  output logic [POSITION_WIDTH-1:0]      reported_position,
  output logic                           reported_valid,
  output logic                           fast_scan
);

  import ssg_pkg::*;

  localparam int unsigned CW = CFG_WIDTH;

  gesture_t                  held_gesture,       held_gesture_next;
  logic [CW-1:0]             big_touch_count,    big_touch_count_next;
  logic [POSITION_WIDTH-1:0] start_position,     start_position_next;
  logic [POSITION_WIDTH-1:0] last_good_position, last_good_position_next;
  logic                      finger_down,        finger_down_next;
  logic [CW-1:0]             touch_ticks,        touch_ticks_next;
  logic                      active_period,      active_period_next;

  logic [MASK_WIDTH+CW-1:0]     mask_ext;
  logic [MASK_WIDTH-1:0]        full_mask;
  logic [MASK_WIDTH-1:0]        bits;
  logic [CW-1:0]                big_inc;
  logic                         rising;
  logic [POSITION_WIDTH-1:0]    travel;
  logic [POSITION_WIDTH+CW-1:0] travel_x;
  logic                         swipe_ok;
  logic                         tap_ok;
  gesture_t                     release_gesture;

  // mask register is zero-extended or cut to the sensor count
  assign mask_ext  = {{MASK_WIDTH{1'b0}}, cfg.slider_sensor_mask};
  assign full_mask = mask_ext[MASK_WIDTH-1:0];
  assign bits      = sensor_on_bits & full_mask;
  assign big_inc   = big_touch_count + CW'(1);

  // lift-off judgement against last good position
  assign rising   = last_good_position > start_position;
  assign travel   = rising ? (last_good_position - start_position)
                           : (start_position - last_good_position);
  assign travel_x = {{CW{1'b0}}, travel};

  assign swipe_ok = (travel_x > {{POSITION_WIDTH{1'b0}}, cfg.swipe_min_distance}) &&
                    (touch_ticks >= cfg.swipe_min_ticks) &&
                    (touch_ticks <  cfg.swipe_max_ticks);
  assign tap_ok   = (travel_x < {{POSITION_WIDTH{1'b0}}, cfg.tap_max_distance}) &&
                    (touch_ticks >= cfg.tap_min_ticks) &&
                    (touch_ticks <  cfg.tap_max_ticks);

  always_comb begin
    priority if (swipe_ok) begin
      release_gesture = rising ? GEST_SWIPE_LEFT : GEST_SWIPE_RIGHT;
    end else if (tap_ok) begin
      release_gesture = GEST_TAP;
    end else begin
      release_gesture = GEST_NONE;
    end
  end

  always_comb begin
    held_gesture_next       = held_gesture;
    big_touch_count_next    = '0;
    start_position_next     = start_position;
    last_good_position_next = last_good_position;
    finger_down_next        = finger_down;
    touch_ticks_next        = '0;
    active_period_next      = active_period;
    reported_position       = '0;
    reported_valid          = 1'b0;

    if (bits == full_mask) begin
      if (big_inc >= cfg.large_object_scans) begin
        held_gesture_next = GEST_LARGE;
      end else begin
        big_touch_count_next = big_inc;
      end
    end

    if (bits == '0) begin
      held_gesture_next = GEST_NONE;
    end

    if (held_gesture_next == GEST_NONE) begin
      if (centroid_present) begin
        reported_position = centroid_position;
        reported_valid    = 1'b1;
      end
      if (bits != '0) begin
        if (centroid_present) begin
          last_good_position_next = centroid_position;
          if (!finger_down) begin
            start_position_next = centroid_position;
            finger_down_next    = 1'b1;
            active_period_next  = 1'b1;
          end
        end
        touch_ticks_next = touch_ticks + CW'(1);
      end else if (finger_down) begin
        finger_down_next   = 1'b0;
        active_period_next = 1'b0;
        held_gesture_next  = release_gesture;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_gesture       <= GEST_NONE;
      big_touch_count    <= '0;
      start_position     <= '0;
      last_good_position <= '0;
      finger_down        <= 1'b0;
      touch_ticks        <= '0;
      active_period      <= 1'b0;
    end else if (step) begin
      held_gesture       <= held_gesture_next;
      big_touch_count    <= big_touch_count_next;
      start_position     <= start_position_next;
      last_good_position <= last_good_position_next;
      finger_down        <= finger_down_next;
      touch_ticks        <= touch_ticks_next;
      active_period      <= active_period_next;
    end
  end

  assign gesture_code = held_gesture_next;
  assign fast_scan    = active_period_next;

endmodule

`default_nettype wire

// ===== rtl/slider_swipe_tap_gesture_detector.sv =====
// ----------------------------------------------------------------------------
// slider_swipe_tap_gesture_detector
// Per-scan slider gesture detection: swipe left/right, tap, large object.
//
//  channel | dir | handshake               | payload
//  s_axis  | in  | tvalid/tready           | tdata: sensors, position; tuser: present
//  m_axis  | out | tvalid/tready           | tdata: gesture, position, fast; tuser: valid
//  cfg     | in  | cfg_we (no back-pressure)| cfg_index, cfg_data
//
//  One scan per cycle sustained while m_axis_tready stays high; each scan
//  passes an input register and then a result register, and leaves from
//  the result register once m_axis_tready is high.
//  The tracking state advances when a scan moves from the input register
//  into the result register; a stalled result holds both stages.
//  rst is synchronous, clears the tracking state and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module slider_swipe_tap_gesture_detector #(
  parameter int unsigned MASK_WIDTH     = ssg_pkg::MASK_WIDTH_DEF,
  parameter int unsigned POSITION_WIDTH = ssg_pkg::POSITION_WIDTH_DEF,
  localparam int unsigned IN_BITS  = MASK_WIDTH + POSITION_WIDTH,
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS = ssg_pkg::GESTURE_WIDTH + POSITION_WIDTH + 1,
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // sensor_on_bits, centroid_position (low to high), zero padded
  input  wire logic [IN_W-1:0]                     s_axis_tdata,
  // centroid_present
  input  wire logic                                s_axis_tuser,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // gesture_code, reported_position, fast_scan (low to high), zero padded
  output logic [OUT_W-1:0]                         m_axis_tdata,
  // reported_valid
  output logic                                     m_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  input  wire logic                                cfg_we,
  input  wire logic [ssg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [ssg_pkg::CFG_WIDTH-1:0]       cfg_data
);

  import ssg_pkg::*;

  cfg_t cfg;

  logic                      in_valid;
  logic [MASK_WIDTH-1:0]     in_bits;
  logic [POSITION_WIDTH-1:0] in_pos;
  logic                      in_present;

  logic                      advance;
  gesture_t                  res_gesture;
  logic [POSITION_WIDTH-1:0] res_pos;
  logic                      res_valid;
  logic                      res_fast;

  logic                      out_valid;
  logic [OUT_BITS-1:0]       out_word;
  logic                      out_user;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  ssg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_bits    <= s_axis_tdata[MASK_WIDTH-1:0];
      in_pos     <= s_axis_tdata[IN_BITS-1:MASK_WIDTH];
      in_present <= s_axis_tuser;
    end
  end

  ssg_track #(
    .MASK_WIDTH     (MASK_WIDTH),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_track (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .step              (advance),
    .sensor_on_bits    (in_bits),
    .centroid_position (in_pos),
    .centroid_present  (in_present),
    .gesture_code      (res_gesture),
    .reported_position (res_pos),
    .reported_valid    (res_valid),
    .fast_scan         (res_fast)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= {res_fast, res_pos, res_gesture};
      out_user <= res_valid;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_W'(out_word);
  assign m_axis_tuser  = out_user;

endmodule

`default_nettype wire
